@@ rtl/rle8_pkg.sv @@
package rle8_pkg;

  // Largest image side the position fields can carry
  localparam int FIELD_LIMIT = 4096;

  // Configuration register indexes
  localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;

  // One decoded result word
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic        clipped;
    logic        image_done;
  } rle8_result_t;

endpackage

@@ rtl/rle8_bitmap_decoder.sv @@
// Path: an accepted byte enters the input register, and its result then
// goes into the result register.
// Throughput: one byte per cycle; the result register takes a new word in the
// same cycle the old one is taken, so only a stalled result holds the input.
// Reset: synchronous; width and height return to 4096 (clamped to the
// parameters), the parser waits for a count byte at the top row.
module rle8_bitmap_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic [7:0]  run_length,
  output logic [7:0]  pixel_value,
  output logic        clipped,
  output logic        image_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rle8_pkg::*;

  localparam int WLIM_I = (MAX_WIDTH < FIELD_LIMIT) ? MAX_WIDTH : FIELD_LIMIT;
  localparam int HLIM_I = (MAX_HEIGHT < FIELD_LIMIT) ? MAX_HEIGHT : FIELD_LIMIT;
  localparam logic [12:0] WLIM = 13'(WLIM_I);
  localparam logic [12:0] HLIM = 13'(HLIM_I);
  localparam logic [12:0] RESET_SIZE = 13'(FIELD_LIMIT);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [12:0] eff_width;
  logic [12:0] eff_height;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_start;
  logic        consume;
  logic        emit;
  rle8_result_t step_result;
  rle8_result_t out_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_SIZE;
      image_height <= RESET_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Saturate the sizes into 1..limit
  always_comb begin
    if (image_width == 13'd0) begin
      eff_width = 13'd1;
    end else if (image_width > WLIM) begin
      eff_width = WLIM;
    end else begin
      eff_width = image_width;
    end
    if (image_height == 13'd0) begin
      eff_height = 13'd1;
    end else if (image_height > HLIM) begin
      eff_height = HLIM;
    end else begin
      eff_height = image_height;
    end
  end

  // Drain the input register unless its result would land on a stalled word
  assign consume  = stage_valid && (!out_valid || out_ready || !emit);
  assign in_ready = !stage_valid || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte  <= data_byte;
      stage_start <= frame_start;
    end
  end

  rle8_parser #(
    .RESET_ROW (HLIM - 13'd1)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (consume),
    .data_byte   (stage_byte),
    .frame_start (stage_start),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .emit        (emit),
    .result      (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_word <= step_result;
    end
  end

  assign column      = out_word.column;
  assign row         = out_word.row;
  assign run_length  = out_word.run_length;
  assign pixel_value = out_word.pixel_value;
  assign clipped     = out_word.clipped;
  assign image_done  = out_word.image_done;

`ifndef SYNTH
  a_end_word_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> column == 12'd0 && run_length == 8'd0 && !clipped)
    else $error("end-of-image word carries run data");

  a_empty_run_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !image_done && run_length == 8'd0 |-> clipped && column == 12'd0)
    else $error("empty run not flagged as clipped");

  a_run_in_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !image_done |->
      ({2'b0, column} + {6'b0, run_length}) <= {1'b0, eff_width})
    else $error("run extends past image width");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !consume |=> stage_valid && $stable(stage_byte))
    else $error("held input word lost");
`endif

endmodule

@@ rtl/rle8_parser.sv @@
module rle8_parser #(
  parameter logic [12:0] RESET_ROW = 13'd4095
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  input  logic [12:0]           eff_width,
  input  logic [12:0]           eff_height,
  output logic                  emit,
  output rle8_pkg::rle8_result_t result
);
  import rle8_pkg::*;

  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_ESCAPE  = 3'd2;
  localparam logic [2:0] PH_DX      = 3'd3;
  localparam logic [2:0] PH_DY      = 3'd4;
  localparam logic [2:0] PH_LITERAL = 3'd5;
  localparam logic [2:0] PH_PAD     = 3'd6;

  localparam logic [7:0] ESC_END_ROW   = 8'd0;
  localparam logic [7:0] ESC_END_IMAGE = 8'd1;
  localparam logic [7:0] ESC_DELTA     = 8'd2;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [12:0] cur_column, cur_column_next;
  logic [12:0] cur_row, cur_row_next;
  logic [7:0]  held_count, held_count_next;
  logic [7:0]  literal_left, literal_left_next;
  logic        literal_odd, literal_odd_next;
  logic [7:0]  delta_columns, delta_columns_next;
  logic        finished, finished_next;

  // State as seen by this word, after an optional frame restart
  logic [2:0]  ph;
  logic [12:0] col;
  logic [12:0] row_now;
  logic        fin;

  // Run arithmetic shared by count runs and literal bytes
  logic [7:0]  run_n;
  logic [12:0] room;
  logic [7:0]  inb;
  logic [7:0]  lit_dec;

  // Add to the column, saturating at the width
  function automatic logic [12:0] col_add(input logic [12:0] c, input logic [7:0] n,
                                          input logic [12:0] w);
    logic [13:0] s;
    s = {1'b0, c} + {6'b0, n};
    col_add = (s > {1'b0, w}) ? w : s[12:0];
  endfunction

  always_comb begin
    ph      = frame_start ? PH_COUNT : parse_phase;
    col     = frame_start ? 13'd0 : cur_column;
    row_now = frame_start ? (eff_height - 13'd1) : cur_row;
    fin     = frame_start ? 1'b0 : finished;

    run_n = (ph == PH_LITERAL) ? 8'd1 : held_count;
    room  = eff_width - col;
    inb   = 8'd0;
    if (col < eff_width) begin
      inb = ({5'b0, run_n} < room) ? run_n : room[7:0];
    end
    lit_dec = (literal_left != 8'd0) ? (literal_left - 8'd1) : 8'd0;
  end

  // Decode one word
  always_comb begin
    parse_phase_next   = ph;
    cur_column_next    = col;
    cur_row_next       = row_now;
    held_count_next    = held_count;
    literal_left_next  = literal_left;
    literal_odd_next   = literal_odd;
    delta_columns_next = delta_columns;
    finished_next      = fin;
    emit               = 1'b0;

    result.column      = (inb != 8'd0) ? col[11:0] : 12'd0;
    result.row         = row_now[11:0];
    result.run_length  = inb;
    result.pixel_value = data_byte;
    result.clipped     = (inb < run_n);
    result.image_done  = 1'b0;

    if (!fin) begin
      case (ph)
        PH_COUNT: begin
          if (data_byte == 8'd0) begin
            parse_phase_next = PH_ESCAPE;
          end else begin
            held_count_next  = data_byte;
            parse_phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          parse_phase_next = PH_COUNT;
          emit             = 1'b1;
          cur_column_next  = col_add(col, run_n, eff_width);
        end
        PH_ESCAPE: begin
          if (data_byte == ESC_END_ROW) begin
            if (row_now == 13'd0) begin
              emit             = 1'b1;
              result           = '0;
              result.image_done = 1'b1;
              finished_next    = 1'b1;
              parse_phase_next = PH_COUNT;
            end else begin
              cur_row_next     = row_now - 13'd1;
              cur_column_next  = 13'd0;
              parse_phase_next = PH_COUNT;
            end
          end else if (data_byte == ESC_END_IMAGE) begin
            emit              = 1'b1;
            result            = '0;
            result.image_done = 1'b1;
            finished_next     = 1'b1;
            parse_phase_next  = PH_COUNT;
          end else if (data_byte == ESC_DELTA) begin
            parse_phase_next = PH_DX;
          end else begin
            literal_left_next = data_byte;
            literal_odd_next  = data_byte[0];
            parse_phase_next  = PH_LITERAL;
          end
        end
        PH_DX: begin
          delta_columns_next = data_byte;
          parse_phase_next   = PH_DY;
        end
        PH_DY: begin
          cur_column_next = col_add(col, delta_columns, eff_width);
          if ({5'b0, data_byte} > row_now) begin
            emit              = 1'b1;
            result            = '0;
            result.image_done = 1'b1;
            finished_next     = 1'b1;
            parse_phase_next  = PH_COUNT;
          end else begin
            cur_row_next     = row_now - {5'b0, data_byte};
            parse_phase_next = PH_COUNT;
          end
        end
        PH_LITERAL: begin
          literal_left_next = lit_dec;
          if (lit_dec == 8'd0) begin
            parse_phase_next = literal_odd ? PH_PAD : PH_COUNT;
          end
          emit            = 1'b1;
          cur_column_next = col_add(col, run_n, eff_width);
        end
        PH_PAD: begin
          parse_phase_next = PH_COUNT;
        end
        default: begin
          parse_phase_next = PH_COUNT;
        end
      endcase
    end
  end

  // Commit the state when the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_COUNT;
      cur_column    <= 13'd0;
      cur_row       <= RESET_ROW;
      held_count    <= 8'd0;
      literal_left  <= 8'd0;
      literal_odd   <= 1'b0;
      delta_columns <= 8'd0;
      finished      <= 1'b0;
    end else if (fire) begin
      parse_phase   <= parse_phase_next;
      cur_column    <= cur_column_next;
      cur_row       <= cur_row_next;
      held_count    <= held_count_next;
      literal_left  <= literal_left_next;
      literal_odd   <= literal_odd_next;
      delta_columns <= delta_columns_next;
      finished      <= finished_next;
    end
  end

endmodule
